### sv/tlb_pkg.sv
// Package for the translation buffer: payload types, request codes and controller links.
`default_nettype none
package tlb_pkg;

  localparam int TLB_ENTRIES_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_INVAL  = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] page;
    logic [7:0] walk_frame;
  } req_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] frame;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic scan;
    logic wr1;
    logic wr2;
    logic load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic occ_zero;
    logic scan_last;
    logic need_wr2;
  } sts_t;

endpackage
`default_nettype wire

### sv/tlb_datapath.sv
// Datapath of the translation buffer: entry memories, scan comparator, minimum search, response.
`default_nettype none
module tlb_datapath
  import tlb_pkg::*;
#(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire req_t req,
  input  wire cmd_t cmd,
  output sts_t      sts,
  output rsp_t      rsp
);

  localparam int IDX_W = $clog2(TLB_ENTRIES);
  localparam int OCC_W = $clog2(TLB_ENTRIES + 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(TLB_ENTRIES);

  logic [7:0]             mem_page  [TLB_ENTRIES];
  logic [7:0]             mem_frame [TLB_ENTRIES];
  logic [COUNT_WIDTH-1:0] mem_count [TLB_ENTRIES];

  logic [OCC_W-1:0]       occ;
  logic [IDX_W-1:0]       idx;
  logic                   scan_q;
  logic [IDX_W-1:0]       cmp_idx;
  logic [7:0]             rd_page;
  logic [7:0]             rd_frame;
  logic [COUNT_WIDTH-1:0] rd_count;

  req_t                   cur;
  logic                   found;
  logic [IDX_W-1:0]       match_idx;
  logic [7:0]             match_frame;
  logic [COUNT_WIDTH-1:0] match_count;
  logic [IDX_W-1:0]       min_idx;
  logic [COUNT_WIDTH-1:0] min_count;
  logic [7:0]             last_page;
  logic [7:0]             last_frame;
  logic [COUNT_WIDTH-1:0] last_count;

  logic [IDX_W-1:0]       last_idx;
  logic                   full;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [7:0]             wr_page;
  logic [7:0]             wr_frame;
  logic [COUNT_WIDTH-1:0] wr_count;
  logic [OCC_W-1:0]       occ_next;

  assign last_idx = IDX_W'(occ - OCC_W'(1));
  assign full     = (occ == OCC_FULL);

  assign sts.occ_zero  = (occ == '0);
  assign sts.scan_last = (idx == last_idx);
  assign sts.need_wr2  = (cur.req_type == REQ_LOOKUP) && !found && full;

  // Write port selection for the two commit steps.
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = match_idx;
    wr_page  = last_page;
    wr_frame = last_frame;
    wr_count = last_count;
    occ_next = occ;
    if (cmd.wr1) begin
      if (cur.req_type == REQ_LOOKUP) begin
        wr_en = 1'b1;
        if (found) begin
          wr_page  = cur.page;
          wr_frame = match_frame;
          wr_count = (match_count == '1) ? match_count : match_count + COUNT_WIDTH'(1);
        end else if (!full) begin
          wr_addr  = occ[IDX_W-1:0];
          wr_page  = cur.page;
          wr_frame = cur.walk_frame;
          wr_count = '0;
          occ_next = occ + OCC_W'(1);
        end else begin
          wr_addr = min_idx;
        end
      end else if (found) begin
        wr_en    = 1'b1;
        occ_next = occ - OCC_W'(1);
      end
    end else if (cmd.wr2) begin
      wr_en    = 1'b1;
      wr_addr  = last_idx;
      wr_page  = cur.page;
      wr_frame = cur.walk_frame;
      wr_count = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_page[wr_addr]  <= wr_page;
      mem_frame[wr_addr] <= wr_frame;
      mem_count[wr_addr] <= wr_count;
    end
    rd_page  <= mem_page[idx];
    rd_frame <= mem_frame[idx];
    rd_count <= mem_count[idx];
    cmp_idx  <= idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ    <= '0;
      idx    <= '0;
      scan_q <= 1'b0;
      found  <= 1'b0;
    end else begin
      occ    <= occ_next;
      scan_q <= cmd.scan;
      if (cmd.start) begin
        idx   <= '0;
        found <= 1'b0;
      end else if (cmd.scan) begin
        idx <= idx + IDX_W'(1);
      end
      if (scan_q && !found && (rd_page == cur.page)) begin
        found <= 1'b1;
      end
    end
  end

  // Per-entry evaluation of the registered read data, request capture and response load.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur <= req;
    end
    if (scan_q) begin
      if (!found && (rd_page == cur.page)) begin
        match_idx   <= cmp_idx;
        match_frame <= rd_frame;
        match_count <= rd_count;
      end
      if ((cmp_idx == '0) || (rd_count < min_count)) begin
        min_idx   <= cmp_idx;
        min_count <= rd_count;
      end
      if (cmp_idx == last_idx) begin
        last_page  <= rd_page;
        last_frame <= rd_frame;
        last_count <= rd_count;
      end
    end
    if (cmd.load) begin
      rsp.hit <= found;
      if (found) begin
        rsp.frame <= match_frame;
      end else if (cur.req_type == REQ_LOOKUP) begin
        rsp.frame <= cur.walk_frame;
      end else begin
        rsp.frame <= '0;
      end
    end
  end

endmodule
`default_nettype wire

### sv/tlb_ctrl.sv
// Controller of the translation buffer: sequences accept, scan, commit writes and response.
`default_nettype none
module tlb_ctrl
  import tlb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_WR1,
    S_WR2,
    S_DONE
  } state_t;

  state_t state;
  logic   rsp_free;

  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd       = '0;
    cmd.start = (state == S_IDLE) && req_valid;
    cmd.scan  = (state == S_SCAN);
    cmd.wr1   = (state == S_WR1);
    cmd.wr2   = (state == S_WR2);
    cmd.load  = (state == S_DONE) && rsp_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // The output register fills when a response is loaded and empties on a transfer.
      if (cmd.load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= sts.occ_zero ? S_WR1 : S_SCAN;
          end
        end
        S_SCAN: begin
          if (sts.scan_last) begin
            state <= S_TAIL;
          end
        end
        S_TAIL: begin
          state <= S_WR1;
        end
        S_WR1: begin
          state <= sts.need_wr2 ? S_WR2 : S_DONE;
        end
        S_WR2: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/tlb_lfu_translate.sv
// Top level of the fully associative translation buffer with least-frequently-used eviction.
//
// Requests arrive on the req channel (req_valid, req_stall, req) and each one
// produces exactly one response transfer on the rsp channel (rsp_valid,
// rsp_stall, rsp). A request is a lookup, which returns the stored frame on a
// hit or the supplied walk frame on a miss, or an invalidate, which returns
// the removed frame, or zero when the page is absent.
// Entries live in three memories with registered reads, so a request scans
// the occupied slots one per cycle. A request then passes a tail step, the
// commit write, a second commit write when a miss on a full buffer needs
// it, and the response load; an empty buffer skips the scan and the tail.
// One request is worked on at a time; the next one may be accepted as soon
// as the previous response is loaded, while that response still waits in
// the output register.
// Reset empties the buffer at once by clearing the occupancy count; the entry
// memories are not cleared, since only occupied slots are ever read.
// While the receiver stalls, the response register holds its value and a
// finished request waits in its final step until the register frees up.
`default_nettype none
module tlb_lfu_translate
  import tlb_pkg::*;
#(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  cmd_t cmd;
  sts_t sts;

  // The controller owns the handshakes and the step sequence.
  tlb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the entries, the occupancy and the response payload.
  tlb_datapath #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule
`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the translation buffer with least-frequently-used eviction.
`timescale 1ns / 1ps
module tb_top;
  import tlb_pkg::*;

  localparam int ENTRIES = TLB_ENTRIES_DEF;
  localparam int CW      = COUNT_WIDTH_DEF;
  // Repeated hits on one page, enough to lift its use count well above the rest.
  localparam int HOT_HITS = 20;
  localparam int RANDOM_ITEMS = 1350;
  // Slowest request is a miss on a full buffer, so allow some margin.
  localparam int DRAIN_CYCLES = ENTRIES + 24;

  typedef struct {
    req_t rq;
    bit   fixed;  // expected response is written into the row
    rsp_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  // Shadow copy of the buffer, kept as the same compact list as the design.
  logic [7:0]    tlb_page[ENTRIES];
  logic [7:0]    tlb_frame[ENTRIES];
  logic [CW-1:0] tlb_uses[ENTRIES];
  int            tlb_fill;

  rsp_t pending_rsp[$];
  int   mismatches = 0;
  bit   calm = 1'b0;  // when set, neither side idles

  always #1 clk = ~clk;

  tlb_lfu_translate i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int idle_cycles();
    int roll;
    if (calm) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  // Moves the last occupied slot into slot dst and shrinks the list by one.
  function automatic void close_gap(input int dst);
    int last;
    last = tlb_fill - 1;
    tlb_page[dst]  = tlb_page[last];
    tlb_frame[dst] = tlb_frame[last];
    tlb_uses[dst]  = tlb_uses[last];
    tlb_fill       = last;
  endfunction

  // Works out the response to one request and updates the shadow buffer.
  function automatic rsp_t tlb_predict(input req_t rq);
    rsp_t res;
    int   slot;
    int   victim;
    int   k;
    slot = -1;
    for (k = 0; k < tlb_fill; k++) begin
      if (slot < 0 && tlb_page[k] == rq.page) begin
        slot = k;
      end
    end
    if (rq.req_type == REQ_LOOKUP) begin
      if (slot >= 0) begin
        // Use counts stick at all ones rather than wrapping.
        if (tlb_uses[slot] != '1) begin
          tlb_uses[slot] = tlb_uses[slot] + CW'(1);
        end
        res.hit   = 1'b1;
        res.frame = tlb_frame[slot];
      end else begin
        if (tlb_fill >= ENTRIES) begin
          // Evict the least used slot; strict compare keeps ties on the lowest index.
          victim = 0;
          for (k = 1; k < ENTRIES; k++) begin
            if (tlb_uses[k] < tlb_uses[victim]) begin
              victim = k;
            end
          end
          close_gap(victim);
        end
        tlb_page[tlb_fill]  = rq.page;
        tlb_frame[tlb_fill] = rq.walk_frame;
        tlb_uses[tlb_fill]  = '0;
        tlb_fill++;
        res.hit   = 1'b0;
        res.frame = rq.walk_frame;
      end
    end else begin
      if (slot >= 0) begin
        res.hit   = 1'b1;
        res.frame = tlb_frame[slot];
        close_gap(slot);
      end else begin
        res.hit   = 1'b0;
        res.frame = '0;
      end
    end
    return res;
  endfunction

  // Presents one request, holds it until the transfer happens, then records what
  // should come back. Valid stays high between back-to-back requests.
  task automatic issue_request(input req_t rq, input bit fixed, input rsp_t want);
    int   gap;
    rsp_t predicted;
    gap = idle_cycles();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= rq;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall !== 1'b0);
    predicted = tlb_predict(rq);
    pending_rsp.push_back(fixed ? want : predicted);
  endtask

  task automatic send_lookup(input logic [7:0] page, input logic [7:0] wf);
    req_t rq;
    rq.req_type   = REQ_LOOKUP;
    rq.page       = page;
    rq.walk_frame = wf;
    issue_request(rq, 1'b0, '0);
  endtask

  function automatic stim_row_t make_row(input logic op, input logic [7:0] page,
                                         input logic [7:0] wf, input bit fixed,
                                         input logic hit, input logic [7:0] frame);
    stim_row_t r;
    r.rq.req_type   = op;
    r.rq.page       = page;
    r.rq.walk_frame = wf;
    r.fixed         = fixed;
    r.want.hit      = hit;
    r.want.frame    = frame;
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input int want, input int got);
    $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    mismatches++;
  endtask

  // Response checker: every transfer on the response channel is matched against
  // the oldest outstanding expectation.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (pending_rsp.size() == 0) begin
        $error("response transfer with no request outstanding: hit %0d frame 0x%0h",
               rsp.hit, rsp.frame);
        mismatches++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.hit !== want.hit) begin
          flag_mismatch("hit", int'(want.hit), int'(rsp.hit));
        end
        if (rsp.frame !== want.frame) begin
          flag_mismatch("frame", int'(want.frame), int'(rsp.frame));
        end
      end
    end
  end

  // Receiver back-pressure: random stall bursts separated by short open windows,
  // so stalls land on every step of the response path.
  initial begin
    int n;
    rsp_stall <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      n = idle_cycles();
      if (n > 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Overall time limit. With the longest gaps and stalls on every request the
  // run needs roughly 0.3 ms; this is several times that.
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    stim_row_t   directed[$];
    req_t        rq;
    logic [7:0]  pool_base;
    int          roll;
    int          k;
    int          n;

    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    tlb_fill  = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part: extremes of page and frame, both request types, the absent
    // invalidate, removal by moving the last slot, filling up and eviction.
    directed.push_back(make_row(REQ_LOOKUP, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00));
    directed.push_back(make_row(REQ_INVAL,  8'h55, 8'hC3, 1'b1, 1'b0, 8'h00));
    directed.push_back(make_row(REQ_LOOKUP, 8'hFF, 8'hFF, 1'b1, 1'b0, 8'hFF));
    directed.push_back(make_row(REQ_LOOKUP, 8'hFF, 8'h00, 1'b1, 1'b1, 8'hFF));
    directed.push_back(make_row(REQ_LOOKUP, 8'h00, 8'hAA, 1'b1, 1'b1, 8'h00));
    directed.push_back(make_row(REQ_INVAL,  8'h00, 8'h12, 1'b1, 1'b1, 8'h00));
    directed.push_back(make_row(REQ_INVAL,  8'h00, 8'h34, 1'b1, 1'b0, 8'h00));
    directed.push_back(make_row(REQ_LOOKUP, 8'h80, 8'h7F, 1'b1, 1'b0, 8'h7F));
    // Fill the remaining fourteen slots; the buffer is full afterwards.
    for (k = 1; k <= 14; k++) begin
      directed.push_back(make_row(REQ_LOOKUP, 8'(k), 8'(k) ^ 8'hA5, 1'b1, 1'b0,
                                  8'(k) ^ 8'hA5));
    end
    directed.push_back(make_row(REQ_LOOKUP, 8'hFF, 8'h01, 1'b0, 1'b0, 8'h00));
    // Miss on a full buffer: a miss always returns the walk frame.
    directed.push_back(make_row(REQ_LOOKUP, 8'h33, 8'h5A, 1'b1, 1'b0, 8'h5A));
    directed.push_back(make_row(REQ_LOOKUP, 8'h80, 8'h11, 1'b1, 1'b0, 8'h11));
    directed.push_back(make_row(REQ_LOOKUP, 8'h0E, 8'h99, 1'b0, 1'b0, 8'h00));
    directed.push_back(make_row(REQ_INVAL,  8'h07, 8'h00, 1'b0, 1'b0, 8'h00));

    foreach (directed[i]) begin
      issue_request(directed[i].rq, directed[i].fixed, directed[i].want);
    end

    // Hot page: empty the buffer, then hit a single page a number of times so
    // that its use count sits well above every other entry.
    rq.req_type = REQ_INVAL;
    while (tlb_fill > 0) begin
      rq.page       = tlb_page[tlb_fill - 1];
      rq.walk_frame = 8'($urandom_range(0, 255));
      issue_request(rq, 1'b0, '0);
    end
    send_lookup(8'h5C, 8'hE7);
    for (n = 0; n < HOT_HITS; n++) begin
      send_lookup(8'h5C, 8'($urandom_range(0, 255)));
    end
    // Fill up with pages used once each; the next miss must then evict one of
    // those rather than the hot page, which should still hit afterwards.
    for (k = 0; k < ENTRIES - 1; k++) begin
      send_lookup(8'hC0 + 8'(k), 8'($urandom_range(0, 255)));
    end
    for (k = 0; k < ENTRIES - 1; k++) begin
      send_lookup(8'hC0 + 8'(k), 8'($urandom_range(0, 255)));
    end
    send_lookup(8'hE0, 8'($urandom_range(0, 255)));
    send_lookup(8'h5C, 8'($urandom_range(0, 255)));

    // Random part. Most lookups come from a window of pages slightly larger than
    // the buffer, which gives a steady mix of hits, misses and evictions; the
    // window moves now and then. Invalidates mostly target resident pages.
    pool_base = 8'($urandom_range(0, 255));
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 149) == 0) begin
        calm = !calm;
      end
      if (n % 200 == 0) begin
        pool_base = 8'($urandom_range(0, 255));
      end
      rq.walk_frame = 8'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        rq.req_type = REQ_INVAL;
        if (tlb_fill > 0 && $urandom_range(0, 2) != 0) begin
          rq.page = tlb_page[$urandom_range(0, tlb_fill - 1)];
        end else begin
          rq.page = 8'($urandom_range(0, 255));
        end
      end else begin
        rq.req_type = REQ_LOOKUP;
        if (roll < 85) begin
          rq.page = pool_base + 8'($urandom_range(0, ENTRIES + 5));
        end else begin
          rq.page = 8'($urandom_range(0, 255));
        end
      end
      issue_request(rq, 1'b0, '0);
    end
    req_valid <= 1'b0;
    calm = 1'b0;

    // Wait for every outstanding response, then a little longer so that any
    // stray extra transfer is caught.
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
